>>> hdl/ojws_pkg.sv
package ojws_pkg;

   localparam int VALUE_W = 32;
   localparam int CNT_W   = $clog2(VALUE_W);

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic        [VALUE_W-1:0] uvalue_type;

   // entry type codes
   localparam logic [1:0] ENT_START  = 2'd0;
   localparam logic [1:0] ENT_END    = 2'd1;
   localparam logic [1:0] ENT_SOURCE = 2'd2;
   localparam logic [1:0] ENT_OTHER  = 2'd3;

   // pass mode codes
   localparam logic [2:0] MODE_LSUM  = 3'd0;
   localparam logic [2:0] MODE_LINT  = 3'd1;
   localparam logic [2:0] MODE_FSUM  = 3'd2;
   localparam logic [2:0] MODE_FINT  = 3'd3;
   localparam logic [2:0] MODE_PROP  = 3'd4;
   localparam logic [2:0] MODE_DEST  = 3'd5;

   typedef struct packed {
      logic       first_item;
      logic [1:0] entry_type;
      logic       open_boundary;
      value_type  join_key;
      value_type  lcl_mult;
      value_type  lcl_cumsum;
      value_type  lcl_interval;
      value_type  lcl_weight;
      value_type  fin_mult;
      value_type  fgn_sum;
      value_type  fgn_interval;
      value_type  dest_index;
   } req_item_type;

   typedef struct packed {
      value_type new_lcl_cumsum;
      value_type new_lcl_interval;
      value_type new_lcl_weight;
      value_type new_fgn_sum;
      value_type new_fgn_interval;
      value_type new_dest_index;
   } rsp_item_type;

   typedef struct packed {
      uvalue_type a;
      uvalue_type b;
      logic       sub;
   } alu_req_type;

   typedef struct packed {
      uvalue_type res;
      logic       carry;
   } alu_rsp_type;

endpackage

>>> hdl/ojws_if.sv
interface ojws_req_if;
   import ojws_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ojws_rsp_if;
   import ojws_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hdl/ojws_alu.sv
module ojws_alu
   import ojws_pkg::*;
(
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   uvalue_type           b_op;
   logic [VALUE_W:0]     sum;

   // carry out set means no borrow on subtract (a >= b unsigned)
   assign b_op = alu_req.sub ? ~alu_req.b : alu_req.b;
   assign sum  = {1'b0, alu_req.a} + {1'b0, b_op} + {{VALUE_W{1'b0}}, alu_req.sub};

   assign alu_rsp.res   = sum[VALUE_W-1:0];
   assign alu_rsp.carry = sum[VALUE_W];

endmodule

>>> hdl/oblivious_join_window_scan_top.sv
// Window scan over a sorted join table, one entry per item.
// req_chan takes one table entry per item (valid/ready, accepted when both
// are high); rsp_chan returns exactly one updated entry per accepted item.
// csr_wr_en/csr_wr_data write pass_mode; write it only while the block idles.
// Each entry is updated from the previous updated entry kept inside the block.
// Timing: the block takes one item at a time and is not ready while it works.
// Most items go from the calculation state straight to the done state. Foreign-sum
// items that need the quotient also run the dividend and divisor negation states, the 32
// restoring-division steps through the single shared adder, the sign fix and
// the add into the foreign sum before the done state.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver still stalls when the following result is
// done, the block holds that result and stays busy until rsp_chan is free.
// Reset (synchronous, active high) clears pass_mode to local sum, empties the
// output register and sets the previous entry to type other with all values 0.
module oblivious_join_window_scan_top
   import ojws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ojws_req_if.sink          req_chan,
   ojws_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_wr_data
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_CALC  = 8'b00000010,
      ST_NEG_N = 8'b00000100,
      ST_NEG_D = 8'b00001000,
      ST_DIV   = 8'b00010000,
      ST_SIGN  = 8'b00100000,
      ST_FSUM  = 8'b01000000,
      ST_DONE  = 8'b10000000
   } state_type;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

   state_type        state_ff, state_in;
   logic [2:0]       mode_ff, mode_in;
   req_item_type     in_ff, in_in;
   rsp_item_type     res_ff, res_in;
   rsp_item_type     rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [1:0]       prev_type_ff, prev_type_in;
   logic             prev_open_ff, prev_open_in;
   value_type        prev_key_ff, prev_key_in;
   value_type        prev_cumsum_ff, prev_cumsum_in;
   value_type        prev_weight_ff, prev_weight_in;
   value_type        prev_fsum_ff, prev_fsum_in;
   value_type        prev_finterval_ff, prev_finterval_in;
   value_type        prev_dest_ff, prev_dest_in;
   value_type        prev_fmult_ff, prev_fmult_in;

   uvalue_type       dv_ff, dv_in;
   uvalue_type       rem_ff, rem_in;
   uvalue_type       quo_ff, quo_in;
   logic             sign_ff, sign_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   alu_req_type      alu_req;
   alu_rsp_type      alu_rsp;

   logic             src_entry;
   logic             skip;
   logic             count_src;
   logic             pair;
   logic             req_take;
   logic             rsp_load;
   uvalue_type       shifted;

   ojws_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign src_entry = in_ff.entry_type == ENT_SOURCE;
   assign skip      = src_entry && prev_type_ff == ENT_START && prev_open_ff
                      && prev_key_ff == in_ff.join_key;
   assign count_src = src_entry && !skip;
   assign pair      = prev_type_ff == ENT_START && in_ff.entry_type == ENT_END;
   assign shifted   = {rem_ff[VALUE_W-2:0], quo_ff[VALUE_W-1]};

   assign req_chan.ready = state_ff == ST_IDLE;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;
   assign rsp_load       = state_ff == ST_DONE && (!rsp_valid_ff || rsp_chan.ready);

   // operands of the shared adder
   always_comb begin
      alu_req.a   = '0;
      alu_req.b   = '0;
      alu_req.sub = 1'b0;
      case (state_ff)
         ST_CALC: begin
            case (mode_ff)
               MODE_LSUM: begin
                  alu_req.a = prev_cumsum_ff;
                  alu_req.b = count_src ? in_ff.lcl_mult : '0;
               end
               MODE_LINT: begin
                  alu_req.a   = in_ff.lcl_cumsum;
                  alu_req.b   = prev_cumsum_ff;
                  alu_req.sub = 1'b1;
               end
               MODE_FSUM: begin
                  alu_req.a   = prev_weight_ff;
                  alu_req.b   = (in_ff.entry_type == ENT_START
                                 || in_ff.entry_type == ENT_END)
                                ? in_ff.lcl_mult : '0;
                  alu_req.sub = in_ff.entry_type == ENT_END;
               end
               MODE_FINT: begin
                  alu_req.a   = in_ff.fgn_sum;
                  alu_req.b   = prev_fsum_ff;
                  alu_req.sub = 1'b1;
               end
               MODE_DEST: begin
                  alu_req.a = prev_dest_ff;
                  alu_req.b = prev_fmult_ff;
               end
               default: begin
               end
            endcase
         end
         ST_NEG_N: begin
            alu_req.b   = in_ff.fin_mult;
            alu_req.sub = 1'b1;
         end
         ST_NEG_D: begin
            alu_req.b   = dv_ff;
            alu_req.sub = 1'b1;
         end
         ST_DIV: begin
            alu_req.a   = shifted;
            alu_req.b   = dv_ff;
            alu_req.sub = 1'b1;
         end
         ST_SIGN: begin
            alu_req.b   = quo_ff;
            alu_req.sub = 1'b1;
         end
         ST_FSUM: begin
            alu_req.a = prev_fsum_ff;
            alu_req.b = quo_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in          = state_ff;
      mode_in           = csr_wr_en ? csr_wr_data : mode_ff;
      in_in             = in_ff;
      res_in            = res_ff;
      rsp_data_in       = rsp_data_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      prev_type_in      = prev_type_ff;
      prev_open_in      = prev_open_ff;
      prev_key_in       = prev_key_ff;
      prev_cumsum_in    = prev_cumsum_ff;
      prev_weight_in    = prev_weight_ff;
      prev_fsum_in      = prev_fsum_ff;
      prev_finterval_in = prev_finterval_ff;
      prev_dest_in      = prev_dest_ff;
      prev_fmult_in     = prev_fmult_ff;
      dv_in             = dv_ff;
      rem_in            = rem_ff;
      quo_in            = quo_ff;
      sign_in           = sign_ff;
      cnt_in            = cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               in_in                   = req_chan.data;
               res_in.new_lcl_cumsum   = req_chan.data.lcl_cumsum;
               res_in.new_lcl_interval = req_chan.data.lcl_interval;
               res_in.new_lcl_weight   = req_chan.data.lcl_weight;
               res_in.new_fgn_sum      = req_chan.data.fgn_sum;
               res_in.new_fgn_interval = req_chan.data.fgn_interval;
               res_in.new_dest_index   = req_chan.data.dest_index;
               state_in                = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_DONE;
            if (!in_ff.first_item) begin
               case (mode_ff)
                  MODE_LSUM: begin
                     res_in.new_lcl_cumsum = alu_rsp.res;
                  end
                  MODE_LINT: begin
                     if (pair) begin
                        res_in.new_lcl_interval = alu_rsp.res;
                     end
                  end
                  MODE_FSUM: begin
                     res_in.new_lcl_weight = alu_rsp.res;
                     if (count_src) begin
                        state_in = ST_NEG_N;
                     end else begin
                        res_in.new_fgn_sum = prev_fsum_ff;
                     end
                  end
                  MODE_FINT: begin
                     if (pair) begin
                        res_in.new_fgn_interval = alu_rsp.res;
                        res_in.new_fgn_sum      = prev_fsum_ff;
                     end
                  end
                  MODE_PROP: begin
                     if (prev_type_ff == ENT_END && src_entry) begin
                        res_in.new_fgn_interval = prev_finterval_ff;
                        res_in.new_fgn_sum      = prev_fsum_ff;
                     end
                  end
                  MODE_DEST: begin
                     res_in.new_dest_index = alu_rsp.res;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_NEG_N: begin
            // magnitude of the dividend; zero weight divides by one
            quo_in   = in_ff.fin_mult[VALUE_W-1] ? alu_rsp.res : in_ff.fin_mult;
            dv_in    = (res_ff.new_lcl_weight != '0) ? res_ff.new_lcl_weight
                                                      : uvalue_type'(1);
            sign_in  = in_ff.fin_mult[VALUE_W-1] ^ res_ff.new_lcl_weight[VALUE_W-1];
            state_in = ST_NEG_D;
         end
         ST_NEG_D: begin
            if (dv_ff[VALUE_W-1]) begin
               dv_in = alu_rsp.res;
            end
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one restoring step: trial subtract of the divisor
            rem_in = alu_rsp.carry ? alu_rsp.res : shifted;
            quo_in = {quo_ff[VALUE_W-2:0], alu_rsp.carry};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            if (sign_ff) begin
               quo_in = alu_rsp.res;
            end
            state_in = ST_FSUM;
         end
         ST_FSUM: begin
            res_in.new_fgn_sum = alu_rsp.res;
            state_in           = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_data_in       = res_ff;
               rsp_valid_in      = 1'b1;
               prev_type_in      = in_ff.entry_type;
               prev_open_in      = in_ff.open_boundary;
               prev_key_in       = in_ff.join_key;
               prev_fmult_in     = in_ff.fin_mult;
               prev_cumsum_in    = res_ff.new_lcl_cumsum;
               prev_weight_in    = res_ff.new_lcl_weight;
               prev_fsum_in      = res_ff.new_fgn_sum;
               prev_finterval_in = res_ff.new_fgn_interval;
               prev_dest_in      = res_ff.new_dest_index;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         mode_ff           <= MODE_LSUM;
         rsp_valid_ff      <= 1'b0;
         prev_type_ff      <= ENT_OTHER;
         prev_open_ff      <= 1'b0;
         prev_key_ff       <= '0;
         prev_cumsum_ff    <= '0;
         prev_weight_ff    <= '0;
         prev_fsum_ff      <= '0;
         prev_finterval_ff <= '0;
         prev_dest_ff      <= '0;
         prev_fmult_ff     <= '0;
         cnt_ff            <= '0;
      end else begin
         state_ff          <= state_in;
         mode_ff           <= mode_in;
         rsp_valid_ff      <= rsp_valid_in;
         prev_type_ff      <= prev_type_in;
         prev_open_ff      <= prev_open_in;
         prev_key_ff       <= prev_key_in;
         prev_cumsum_ff    <= prev_cumsum_in;
         prev_weight_ff    <= prev_weight_in;
         prev_fsum_ff      <= prev_fsum_in;
         prev_finterval_ff <= prev_finterval_in;
         prev_dest_ff      <= prev_dest_in;
         prev_fmult_ff     <= prev_fmult_in;
         cnt_ff            <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff       <= in_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      dv_ff       <= dv_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      sign_ff     <= sign_in;
   end

   a_take_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_CALC)
      else $error("accepted item did not start processing");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |=> rem_ff < dv_ff)
      else $error("division remainder not below divisor");

   a_div_step_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == CNT_LAST) |=> state_ff == ST_SIGN)
      else $error("division did not end after last step");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_chan.ready) |=> state_ff == ST_DONE)
      else $error("finished item left while output register was full");

   a_load_shows_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result load did not raise valid");

endmodule

>>> dv/window_scan_checker.sv
`timescale 1ns / 100ps

module window_scan_checker
   import ojws_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_data,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_wr_data,
   output int           mismatch_count,
   output int           outstanding
);

   logic [2:0]   pass_mode;
   logic [1:0]   last_type;
   logic         last_open;
   value_type    last_key;
   value_type    last_cumsum;
   value_type    last_weight;
   value_type    last_fsum;
   value_type    last_finterval;
   value_type    last_dest;
   value_type    last_fmult;
   rsp_item_type updated_entries[$];
   int           fail_total = 0;

   assign mismatch_count = fail_total;

   // truncating signed quotient, most negative / -1 wraps back to itself
   function automatic value_type trunc_quotient(value_type num, value_type den);
      uvalue_type mag_n;
      uvalue_type mag_d;
      uvalue_type quo;
      mag_n = num[VALUE_W-1] ? uvalue_type'(-num) : uvalue_type'(num);
      mag_d = den[VALUE_W-1] ? uvalue_type'(-den) : uvalue_type'(den);
      quo = mag_n / mag_d;
      if (num[VALUE_W-1] != den[VALUE_W-1])
         quo = -quo;
      return value_type'(quo);
   endfunction

   // updates one table entry from the previous updated entry and keeps it
   function automatic rsp_item_type scan_entry(req_item_type e);
      rsp_item_type r;
      logic         is_src;
      logic         skip_src;
      logic         pair;
      value_type    divisor;
      r.new_lcl_cumsum   = e.lcl_cumsum;
      r.new_lcl_interval = e.lcl_interval;
      r.new_lcl_weight   = e.lcl_weight;
      r.new_fgn_sum      = e.fgn_sum;
      r.new_fgn_interval = e.fgn_interval;
      r.new_dest_index   = e.dest_index;
      is_src   = (e.entry_type == ENT_SOURCE);
      skip_src = is_src && last_type == ENT_START && last_open && last_key == e.join_key;
      pair     = (last_type == ENT_START) && (e.entry_type == ENT_END);
      if (!e.first_item) begin
         case (pass_mode)
            MODE_LSUM: begin
               r.new_lcl_cumsum = last_cumsum
                                  + ((is_src && !skip_src) ? e.lcl_mult : '0);
            end
            MODE_LINT: begin
               if (pair)
                  r.new_lcl_interval = e.lcl_cumsum - last_cumsum;
            end
            MODE_FSUM: begin
               if (e.entry_type == ENT_START)
                  r.new_lcl_weight = last_weight + e.lcl_mult;
               else if (e.entry_type == ENT_END)
                  r.new_lcl_weight = last_weight - e.lcl_mult;
               else
                  r.new_lcl_weight = last_weight;
               divisor = (r.new_lcl_weight != 0) ? r.new_lcl_weight : value_type'(1);
               if (is_src && !skip_src)
                  r.new_fgn_sum = last_fsum + trunc_quotient(e.fin_mult, divisor);
               else
                  r.new_fgn_sum = last_fsum;
            end
            MODE_FINT: begin
               if (pair) begin
                  r.new_fgn_interval = e.fgn_sum - last_fsum;
                  r.new_fgn_sum      = last_fsum;
               end
            end
            MODE_PROP: begin
               if (last_type == ENT_END && is_src) begin
                  r.new_fgn_interval = last_finterval;
                  r.new_fgn_sum      = last_fsum;
               end
            end
            MODE_DEST: begin
               r.new_dest_index = last_dest + last_fmult;
            end
            default: ;
         endcase
      end
      last_type      = e.entry_type;
      last_open      = e.open_boundary;
      last_key       = e.join_key;
      last_cumsum    = r.new_lcl_cumsum;
      last_weight    = r.new_lcl_weight;
      last_fsum      = r.new_fgn_sum;
      last_finterval = r.new_fgn_interval;
      last_dest      = r.new_dest_index;
      last_fmult     = e.fin_mult;
      return r;
   endfunction

   task automatic check_field(input string what, input value_type want, input value_type got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         pass_mode      = MODE_LSUM;
         last_type      = ENT_OTHER;
         last_open      = 1'b0;
         last_key       = '0;
         last_cumsum    = '0;
         last_weight    = '0;
         last_fsum      = '0;
         last_finterval = '0;
         last_dest      = '0;
         last_fmult     = '0;
         updated_entries.delete();
      end else begin
         if (csr_wr_en)
            pass_mode = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (updated_entries.size() == 0) begin
               $display("%0t: result with no entry waiting, expected none, actual cumsum %0d",
                        $time, rsp_data.new_lcl_cumsum);
               fail_total++;
            end else begin
               want = updated_entries.pop_front();
               check_field("lcl_cumsum", want.new_lcl_cumsum, rsp_data.new_lcl_cumsum);
               check_field("lcl_interval", want.new_lcl_interval,
                           rsp_data.new_lcl_interval);
               check_field("lcl_weight", want.new_lcl_weight, rsp_data.new_lcl_weight);
               check_field("fgn_sum", want.new_fgn_sum, rsp_data.new_fgn_sum);
               check_field("fgn_interval", want.new_fgn_interval,
                           rsp_data.new_fgn_interval);
               check_field("dest_index", want.new_dest_index, rsp_data.new_dest_index);
            end
         end
         if (req_valid && req_ready)
            updated_entries.push_back(scan_entry(req_data));
      end
      outstanding <= updated_entries.size();
   end

endmodule

>>> dv/tb_oblivious_join_window_scan_top.sv
`timescale 1ns / 100ps

module tb_oblivious_join_window_scan_top
   import ojws_pkg::*;
();

   // pass modes with no rule of their own
   localparam logic [2:0] MODE_RSVD_LO = 3'd6;
   localparam logic [2:0] MODE_RSVD_HI = 3'd7;

   localparam value_type VAL_MAX = value_type'(32'h7fff_ffff);
   localparam value_type VAL_MIN = value_type'(32'h8000_0000);

   localparam int RANDOM_ITEMS     = 1750;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES     = 60;
   localparam int TIMEOUT_CYCLES   = 1_500_000;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [2:0] csr_wr_data = MODE_LSUM;
   int         mismatch_count;
   int         outstanding;
   int         items_sent  = 0;
   int         phase_left  = 0;
   int         burst_left  = 0;
   bit         rsp_hold_req = 1'b0;

   ojws_req_if req_if();
   ojws_rsp_if rsp_if();

   oblivious_join_window_scan_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   window_scan_checker scan_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_data       (req_if.data),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_data       (rsp_if.data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // small values so sums and quotients stay readable, full-range values and some extremes
   function automatic value_type pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         case ($urandom_range(0, 4))
            0: return '0;
            1: return value_type'(1);
            2: return value_type'(-1);
            3: return VAL_MAX;
            default: return VAL_MIN;
         endcase
      end else if (sel < 5) begin
         return value_type'($urandom_range(0, 40)) - value_type'(20);
      end
      return value_type'($urandom);
   endfunction

   function automatic req_item_type make_entry(logic first, logic [1:0] kind, value_type key);
      req_item_type e;
      e.first_item    = first;
      e.entry_type    = kind;
      e.open_boundary = 1'($urandom_range(0, 1));
      e.join_key      = key;
      e.lcl_mult      = pick_value();
      e.lcl_cumsum    = pick_value();
      e.lcl_interval  = pick_value();
      e.lcl_weight    = pick_value();
      e.fin_mult      = pick_value();
      e.fgn_sum       = pick_value();
      e.fgn_interval  = pick_value();
      e.dest_index    = pick_value();
      return e;
   endfunction

   // valid stays high into the next item unless a gap follows
   task automatic send_entry(input req_item_type e);
      req_if.valid <= 1'b1;
      req_if.data  <= e;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_paced(input req_item_type e);
      send_entry(e);
      items_sent++;
      phase_left--;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 45)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 15);
      end
   endtask

   // pass_mode may only change once every item has come back
   task automatic change_mode(input logic [2:0] mode);
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // tables of start/source/end groups under random keys, with some stray items mixed in
   task automatic run_table_phase(input int n);
      value_type key;
      int        srcs;
      bit        srcs_inside;
      phase_left = n;
      while (phase_left > 0) begin
         if ($urandom_range(0, 6) == 0) begin
            send_paced(make_entry($urandom_range(0, 15) == 0, 2'($urandom_range(0, 3)),
                                  pick_value()));
         end else begin
            send_paced(make_entry(1'b1, 2'($urandom_range(0, 3)), pick_value()));
            repeat ($urandom_range(1, 6)) begin
               key         = pick_value();
               srcs        = $urandom_range(0, 4);
               srcs_inside = 1'($urandom_range(0, 1));
               if ($urandom_range(0, 4) == 0)
                  send_paced(make_entry(1'b0, ENT_OTHER, key));
               send_paced(make_entry(1'b0, ENT_START, key));
               if (!srcs_inside)
                  send_paced(make_entry(1'b0, ENT_END, key));
               repeat (srcs)
                  send_paced(make_entry(1'b0, ENT_SOURCE,
                                        ($urandom_range(0, 5) == 0) ? pick_value() : key));
               if (srcs_inside)
                  send_paced(make_entry(1'b0, ENT_END, key));
            end
         end
      end
   endtask

   initial begin : rsp_stall
      int on_len;
      int off_len;
      rsp_if.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         on_len  = $urandom_range(1, 40);
         off_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         rsp_if.ready <= 1'b1;
         repeat (on_len) @(posedge clock);
         if (off_len > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (off_len) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * 10);
      $display("tb_oblivious_join_window_scan_top: done, errors");
      $finish;
   end

   initial begin : stimulus
      req_item_type e;
      logic [2:0]   mode;
      req_if.valid = 1'b0;
      req_if.data  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // local sum straight out of reset, no first entry yet
      e = make_entry(1'b0, ENT_SOURCE, '0);
      e.lcl_mult = VAL_MAX;
      send_paced(e);
      e = make_entry(1'b0, ENT_SOURCE, VAL_MAX);
      e.lcl_mult = value_type'(1);
      send_paced(e);
      e = make_entry(1'b0, ENT_START, VAL_MIN);
      e.open_boundary = 1'b1;
      send_paced(e);
      // source right behind an open start of the same key is skipped
      e = make_entry(1'b0, ENT_SOURCE, VAL_MIN);
      e.lcl_mult = value_type'(5);
      send_paced(e);
      e = make_entry(1'b0, ENT_SOURCE, VAL_MAX);
      e.lcl_mult = VAL_MIN;
      send_paced(e);
      e = make_entry(1'b1, ENT_OTHER, VAL_MAX);
      e.open_boundary = 1'b1;
      e.lcl_mult = VAL_MAX;
      e.lcl_cumsum = VAL_MAX;
      e.lcl_interval = VAL_MAX;
      e.lcl_weight = VAL_MAX;
      e.fin_mult = VAL_MAX;
      e.fgn_sum = VAL_MAX;
      e.fgn_interval = VAL_MAX;
      e.dest_index = VAL_MAX;
      send_paced(e);

      change_mode(MODE_LINT);
      e = make_entry(1'b0, ENT_START, value_type'(3));
      e.lcl_cumsum = value_type'(10);
      send_paced(e);
      e = make_entry(1'b0, ENT_END, value_type'(3));
      e.lcl_cumsum = VAL_MIN;
      send_paced(e);
      send_paced(make_entry(1'b0, ENT_END, value_type'(3)));

      change_mode(MODE_FSUM);
      e = make_entry(1'b1, ENT_START, value_type'(9));
      e.lcl_weight = '0;
      e.fgn_sum    = '0;
      send_paced(e);
      e = make_entry(1'b0, ENT_START, value_type'(9));
      e.lcl_mult = value_type'(-1);
      send_paced(e);
      // weight -1 and the most negative final multiplicity: quotient overflows
      e = make_entry(1'b0, ENT_SOURCE, value_type'(8));
      e.fin_mult = VAL_MIN;
      send_paced(e);
      e = make_entry(1'b0, ENT_END, value_type'(8));
      e.lcl_mult = value_type'(-1);
      send_paced(e);
      // weight now zero, divides by one
      e = make_entry(1'b0, ENT_SOURCE, value_type'(8));
      e.fin_mult = value_type'(-7);
      send_paced(e);
      e = make_entry(1'b0, ENT_START, value_type'(42));
      e.open_boundary = 1'b1;
      e.lcl_mult = value_type'(3);
      send_paced(e);
      send_paced(make_entry(1'b0, ENT_SOURCE, value_type'(42)));
      e = make_entry(1'b0, ENT_SOURCE, value_type'(43));
      e.fin_mult = value_type'(100);
      send_paced(e);

      change_mode(MODE_FINT);
      e = make_entry(1'b0, ENT_START, value_type'(1));
      e.fgn_sum = value_type'(5);
      send_paced(e);
      e = make_entry(1'b0, ENT_END, value_type'(1));
      e.fgn_sum = VAL_MIN;
      send_paced(e);

      change_mode(MODE_PROP);
      send_paced(make_entry(1'b0, ENT_END, value_type'(2)));
      send_paced(make_entry(1'b0, ENT_SOURCE, value_type'(2)));

      change_mode(MODE_DEST);
      e = make_entry(1'b0, ENT_OTHER, '0);
      e.fin_mult = VAL_MAX;
      send_paced(e);
      e = make_entry(1'b0, ENT_OTHER, '0);
      e.fin_mult = value_type'(-1);
      send_paced(e);

      change_mode(MODE_RSVD_LO);
      send_paced(make_entry(1'b0, ENT_START, value_type'(4)));
      change_mode(MODE_RSVD_HI);
      send_paced(make_entry(1'b0, ENT_END, value_type'(4)));

      // first random phase runs against a long stall of the result side
      change_mode(MODE_LSUM);
      rsp_hold_req = 1'b1;
      run_table_phase(150);
      while (items_sent < RANDOM_ITEMS + 25) begin
         if ($urandom_range(0, 9) == 0)
            mode = $urandom_range(0, 1) ? MODE_RSVD_LO : MODE_RSVD_HI;
         else
            mode = 3'($urandom_range(0, 5));
         change_mode(mode);
         run_table_phase($urandom_range(40, 140));
      end

      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_oblivious_join_window_scan_top: done, clean");
      else
         $display("tb_oblivious_join_window_scan_top: done, errors");
      $finish;
   end

endmodule
